[rtl/ordered_list_append_delete_macros.svh]
// Assertion macros for the ordered list block.
// Included by the modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef ORDERED_LIST_APPEND_DELETE_MACROS_SVH
`define ORDERED_LIST_APPEND_DELETE_MACROS_SVH
`ifndef SYNTHESIS
`define OLAD_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OLAD_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OLAD_CHECK(lbl, prop, msg)
`define OLAD_CHECK_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/olad_pkg.sv]
// Shared constants, codes and cell control types for the ordered list block.
// No dependencies; used by the interfaces, the cell and the top level.
package olad_pkg;

    localparam int CAPACITY = 16;

    localparam int VAL_W   = 32;
    localparam int OPC_W   = 2;
    localparam int POS_W   = 8;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;
    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    // request opcodes
    localparam logic [OPC_W-1:0] OP_APPEND    = 2'd0;
    localparam logic [OPC_W-1:0] OP_DEL_VALUE = 2'd1;
    localparam logic [OPC_W-1:0] OP_DEL_POS   = 2'd2;

    // response status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    // compare controls broadcast to every cell
    typedef struct packed {
        logic              del_val;
        logic              del_pos;
        logic [VAL_W-1:0]  value;
        logic [POS_W-1:0]  pos_m1;
        logic [CNT_W-1:0]  count;
    } cell_cmd_t;

    // write strobes broadcast to every cell
    typedef struct packed {
        logic del;
        logic app;
    } cell_wr_t;

endpackage

[rtl/olad_intf.sv]
// Request and response channel interfaces for the ordered list block.
// Depends on olad_pkg for field widths.
interface olad_req_if;
    logic                              valid;
    logic                              ready;
    logic [olad_pkg::OPC_W-1:0]        opcode;
    logic signed [olad_pkg::VAL_W-1:0] value;
    logic [olad_pkg::POS_W-1:0]        position;

    modport source (output valid, output opcode, output value, output position, input ready);
    modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

interface olad_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [olad_pkg::STAT_W-1:0]   status;
    logic [olad_pkg::COUNT_W-1:0]  count;

    modport source (output valid, output status, output count, input ready);
    modport sink   (input valid, input status, input count, output ready);
endinterface

[rtl/olad_cell.sv]
// One slot of the list: holds an entry, compares it and shifts from its upper neighbor.
// Depends on olad_pkg.
module olad_cell (
    input  logic                           clk,
    input  logic [olad_pkg::IDX_W-1:0]     idx,
    input  olad_pkg::cell_cmd_t            cmd,
    input  olad_pkg::cell_wr_t             wr,
    input  logic                           hit_in,
    input  logic [olad_pkg::VAL_W-1:0]     upper_data,
    output logic                           hit_out,
    output logic [olad_pkg::VAL_W-1:0]     data
);

    logic [olad_pkg::VAL_W-1:0] data_reg;
    logic [olad_pkg::VAL_W-1:0] data_next;
    logic                       occupied;
    logic                       hit_here;
    logic                       append_here;

    assign occupied    = olad_pkg::CNT_W'(idx) < cmd.count;
    assign append_here = olad_pkg::CNT_W'(idx) == cmd.count;
    assign hit_here    = occupied &&
                         ((cmd.del_val && (data_reg == cmd.value)) ||
                          (cmd.del_pos && (olad_pkg::POS_W'(idx) == cmd.pos_m1)));
    // a hit here or below means this slot closes the gap
    assign hit_out     = hit_in || hit_here;
    assign data        = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (wr.del && hit_out)
        begin
            data_next = upper_data;
        end
        else if (wr.app && append_here)
        begin
            data_next = cmd.value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

[rtl/ordered_list_append_delete.sv]
// Top level of the ordered list block: command decode, entry count and the row of cells.
// Depends on olad_pkg, olad_intf.sv, olad_cell and ordered_list_append_delete_macros.svh.
//
//   channel | dir | payload                      | accepted when
//   --------+-----+------------------------------+---------------------------
//   req     | in  | opcode, value, position      | req.valid && req.ready
//   rsp     | out | status, count                | rsp.valid && rsp.ready
//
// Each request finishes in the cycle it is accepted; its response appears in the output
// register on the next cycle. One request per cycle is sustained while responses are taken.
// The rate is set by the cell row: all slots compare against the request and shift toward
// the head in the same cycle, with the match flag rippling from slot 0 to the last slot.
// Reset clears the entry count and the response valid; slot contents are left as they are.
// A response that is not taken holds the output register and stalls the request side.
`include "ordered_list_append_delete_macros.svh"

module ordered_list_append_delete (
    input  logic                clk,
    input  logic                rst_n,
    olad_req_if.sink            req,
    olad_rsp_if.source          rsp
);

    logic [olad_pkg::CNT_W-1:0]   count_reg;
    logic [olad_pkg::CNT_W-1:0]   count_next;
    logic                         rsp_valid_reg;
    logic [olad_pkg::STAT_W-1:0]  rsp_status_reg;
    logic [olad_pkg::COUNT_W-1:0] rsp_count_reg;

    logic                         req_acc;
    logic [olad_pkg::STAT_W-1:0]  status_next;
    logic                         list_full;
    logic                         list_empty;
    logic                         found;

    olad_pkg::cell_cmd_t          cmd;
    olad_pkg::cell_wr_t           wr;
    logic                         hit_chain [olad_pkg::CAPACITY+1];
    logic [olad_pkg::VAL_W-1:0]   cell_data [olad_pkg::CAPACITY];

    // take a new request whenever the output register is free or being emptied
    assign req.ready  = !rsp_valid_reg || rsp.ready;
    assign req_acc    = req.valid && req.ready;

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.status = rsp_status_reg;
    assign rsp.count  = rsp_count_reg;

    assign list_full  = count_reg == olad_pkg::CNT_W'(olad_pkg::CAPACITY);
    assign list_empty = count_reg == '0;

    // broadcast the request to the cell row
    assign cmd.del_val = req.opcode == olad_pkg::OP_DEL_VALUE;
    assign cmd.del_pos = req.opcode == olad_pkg::OP_DEL_POS;
    assign cmd.value   = $unsigned(req.value);
    assign cmd.pos_m1  = req.position - olad_pkg::POS_W'(1);
    assign cmd.count   = count_reg;

    assign hit_chain[0] = 1'b0;
    assign found        = hit_chain[olad_pkg::CAPACITY];

    for (genvar k = 0; k < olad_pkg::CAPACITY; k++)
    begin : g_cell
        logic [olad_pkg::VAL_W-1:0] upper;

        // last slot has no upper neighbor; what it takes lies beyond the new count
        if (k == olad_pkg::CAPACITY - 1)
        begin : g_last
            assign upper = cell_data[k];
        end
        else
        begin : g_mid
            assign upper = cell_data[k+1];
        end

        olad_cell u_cell (
            .clk        (clk),
            .idx        (olad_pkg::IDX_W'(k)),
            .cmd        (cmd),
            .wr         (wr),
            .hit_in     (hit_chain[k]),
            .upper_data (upper),
            .hit_out    (hit_chain[k+1]),
            .data       (cell_data[k])
        );
    end

    // decide the outcome of the request
    always_comb
    begin
        case (req.opcode)
            olad_pkg::OP_APPEND:
            begin
                status_next = list_full ? olad_pkg::ST_FULL : olad_pkg::ST_DONE;
            end
            olad_pkg::OP_DEL_VALUE:
            begin
                if (list_empty)
                begin
                    status_next = olad_pkg::ST_EMPTY;
                end
                else
                begin
                    status_next = found ? olad_pkg::ST_DONE : olad_pkg::ST_MISS;
                end
            end
            olad_pkg::OP_DEL_POS:
            begin
                if (list_empty || (req.position == '0))
                begin
                    status_next = olad_pkg::ST_EMPTY;
                end
                else if (olad_pkg::CMP_W'(req.position) > olad_pkg::CMP_W'(count_reg))
                begin
                    status_next = olad_pkg::ST_MISS;
                end
                else
                begin
                    status_next = olad_pkg::ST_DONE;
                end
            end
            default:
            begin
                // unused opcode: drop the request, leave the list alone
                status_next = olad_pkg::ST_MISS;
            end
        endcase
    end

    // commit only successful requests
    always_comb
    begin
        wr.app     = req_acc && (status_next == olad_pkg::ST_DONE) &&
                     (req.opcode == olad_pkg::OP_APPEND);
        wr.del     = req_acc && (status_next == olad_pkg::ST_DONE) &&
                     (cmd.del_val || cmd.del_pos);
        count_next = count_reg;
        if (wr.app)
        begin
            count_next = count_reg + olad_pkg::CNT_W'(1);
        end
        else if (wr.del)
        begin
            count_next = count_reg - olad_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (req_acc)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // response payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            rsp_status_reg <= status_next;
            rsp_count_reg  <= olad_pkg::COUNT_W'(count_next);
        end
    end

    `OLAD_CHECK(a_count_bound,
        count_reg <= olad_pkg::CNT_W'(olad_pkg::CAPACITY),
        "entry count above capacity")
    `OLAD_CHECK(a_append_grows,
        (req_acc && (req.opcode == olad_pkg::OP_APPEND) && !list_full) |=>
            (count_reg == $past(count_reg) + olad_pkg::CNT_W'(1)),
        "append did not grow the list")
    `OLAD_CHECK(a_delete_shrinks,
        (req_acc && (cmd.del_val || cmd.del_pos) && (status_next == olad_pkg::ST_DONE)) |=>
            (count_reg == $past(count_reg) - olad_pkg::CNT_W'(1)),
        "delete did not shrink the list")
    `OLAD_CHECK(a_fail_keeps_count,
        (req_acc && (status_next != olad_pkg::ST_DONE)) |=> $stable(count_reg),
        "failed request changed the count")
    `OLAD_CHECK(a_stall_only_when_held,
        !req.ready |-> rsp_valid_reg,
        "request stalled with no response held")

endmodule
